@@ rtl/mwmma_pkg.sv @@
// Shared types, constants and helper functions for the windowed min/max/mean core.
// Used by every module of the block; has no dependencies of its own.
package mwmma_pkg;

    // Default values for the top-level parameters.
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int MAX_WINDOW_DEF   = 12;

    // Fixed field widths.
    localparam int CHAN_BITS   = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int SUM_BITS    = 24;
    localparam int SCALE_BITS  = 16;
    localparam int OUT_BITS    = 20;
    localparam int FRAC_BITS   = 8;
    localparam int WIN_BITS    = 5;
    localparam int WIN_CFG_BITS = 4;
    localparam int MIN_WINDOW  = 4;

    // Product widths: unsigned operand plus sign bit times the signed gain.
    localparam int PSUM_BITS = SUM_BITS + 1 + SCALE_BITS;
    localparam int PSMP_BITS = SAMPLE_BITS + 1 + SCALE_BITS;

    // Result queue depth; it also bounds the results in flight in the back end.
    localparam int RES_DEPTH = 4;

    // Configuration port.
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_LOG2 = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_MV_Q8 = 2'd1;
    localparam logic [WIN_CFG_BITS-1:0] WINDOW_RESET = 4'd10;
    localparam logic signed [SCALE_BITS-1:0] SCALE_RESET = 16'sd1889;

    // Saturation bounds of the signed output range, at product width.
    localparam logic signed [PSUM_BITS-1:0] SAT_HI =
        PSUM_BITS'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [PSUM_BITS-1:0] SAT_LO = -SAT_HI - PSUM_BITS'(1);

    typedef struct packed {
        logic [SUM_BITS-1:0]    sum;
        logic [SAMPLE_BITS-1:0] maxv;
        logic [SAMPLE_BITS-1:0] minv;
    } acc_entry_t;

    localparam acc_entry_t ACC_RESET = '{sum: '0, maxv: '0, minv: '1};

    typedef struct packed {
        logic [CHAN_BITS-1:0]       out_channel;
        logic signed [OUT_BITS-1:0] avg_mv;
        logic signed [OUT_BITS-1:0] max_mv;
        logic signed [OUT_BITS-1:0] min_mv;
        logic                       last;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } back_state_t;

    // Clamp the programmed window to the supported range.
    function automatic logic [WIN_BITS-1:0] clamp_window(
        input logic [WIN_CFG_BITS-1:0] w,
        input int                      max_w
    );
        logic [WIN_BITS-1:0] r;
        begin
            r = WIN_BITS'(w);
            if (int'(w) < MIN_WINDOW) begin
                r = WIN_BITS'(MIN_WINDOW);
            end
            else if (int'(w) > max_w) begin
                r = WIN_BITS'(max_w);
            end
            return r;
        end
    endfunction

    // Saturate a signed product-width value to the signed output range.
    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [PSUM_BITS-1:0] v
    );
        logic signed [OUT_BITS-1:0] r;
        begin
            r = v[OUT_BITS-1:0];
            if (v > SAT_HI) begin
                r = SAT_HI[OUT_BITS-1:0];
            end
            else if (v < SAT_LO) begin
                r = SAT_LO[OUT_BITS-1:0];
            end
            return r;
        end
    endfunction

endpackage

@@ rtl/mwmma_front.sv @@
// Front end: per-channel sum/max/min accumulators and the scan counter.
// Detects the window close and presents the snapshot. Depends on mwmma_pkg.
module mwmma_front
    import mwmma_pkg::*;
#(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [CHAN_BITS-1:0]              channel,
    input  logic [SAMPLE_BITS-1:0]            sample,
    input  logic [WIN_BITS-1:0]               win_eff,
    input  logic                              bank_busy,
    output logic                              full,
    output logic                              close,
    output acc_entry_t [NUM_CHANNELS-1:0]     snap_data
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SCAN_W = MAX_WINDOW_LOG2 + 1;

    acc_entry_t acc_reg  [NUM_CHANNELS];
    acc_entry_t acc_next [NUM_CHANNELS];
    logic [SCAN_W-1:0] scan_count_reg;
    logic [SCAN_W-1:0] scan_count_next;

    logic              ch_ok;
    logic              ch_last;
    logic [CH_W-1:0]   idx;
    acc_entry_t        cur;
    acc_entry_t        upd;
    logic [SUM_BITS:0] sum_wide;
    logic [SCAN_W-1:0] scan_inc;
    logic [SCAN_W-1:0] thresh;
    logic              at_final;
    logic              hit;

    assign ch_ok   = int'(channel) < NUM_CHANNELS;
    assign ch_last = int'(channel) == NUM_CHANNELS - 1;
    assign idx     = CH_W'(channel);
    assign cur     = acc_reg[idx];

    // Saturating sum and running extremes for the addressed channel.
    assign sum_wide = {1'b0, cur.sum} + (SUM_BITS + 1)'(sample);
    always_comb
    begin
        upd.sum  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
        upd.maxv = (sample > cur.maxv) ? sample : cur.maxv;
        upd.minv = (sample < cur.minv) ? sample : cur.minv;
    end

    // The scan that the next last-channel sample completes closes the window.
    assign scan_inc = scan_count_reg + SCAN_W'(1);
    assign thresh   = SCAN_W'(1) << win_eff;
    assign at_final = scan_inc >= thresh;

    // Hold off only while the snapshot bank is still draining and a close could come.
    assign full  = bank_busy && at_final;
    assign hit   = accept && ch_ok;
    assign close = hit && ch_last && at_final;

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            snap_data[i] = (hit && (idx == CH_W'(i))) ? upd : acc_reg[i];
            acc_next[i]  = close ? ACC_RESET : snap_data[i];
        end
    end

    always_comb
    begin
        scan_count_next = scan_count_reg;
        if (hit && ch_last) begin
            scan_count_next = close ? '0 : scan_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                acc_reg[i] <= ACC_RESET;
            end
            scan_count_reg <= '0;
        end
        else begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                acc_reg[i] <= acc_next[i];
            end
            scan_count_reg <= scan_count_next;
        end
    end

endmodule

@@ rtl/mwmma_bank.sv @@
// Snapshot bank: holds one closed window's statistics while the back end drains it.
// Acts as the one-window queue between front and back. Depends on mwmma_pkg.
module mwmma_bank
    import mwmma_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  acc_entry_t [NUM_CHANNELS-1:0] load_data,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_idx,
    input  logic                          drain_done,
    output logic                          busy,
    output acc_entry_t                    rd_data
);

    acc_entry_t bank_reg [NUM_CHANNELS];
    logic       busy_reg;
    logic       busy_next;

    always_comb
    begin
        busy_next = busy_reg;
        if (load) begin
            busy_next = 1'b1;
        end
        else if (drain_done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                bank_reg[i] <= load_data[i];
            end
        end
    end

    assign busy    = busy_reg;
    assign rd_data = bank_reg[rd_idx];

endmodule

@@ rtl/mwmma_back.sv @@
// Back end: walks the snapshot bank channel by channel and scales each entry.
// Three stages: bank read, multiply, floor shift with saturation. Depends on mwmma_pkg.
module mwmma_back
    import mwmma_pkg::*;
#(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           bank_busy,
    input  acc_entry_t                     rd_data,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_idx,
    output logic                           drain_done,
    input  logic [WIN_BITS-1:0]            win_eff,
    input  logic signed [SCALE_BITS-1:0]   scale,
    input  logic                           pop_fire,
    output logic                           res_valid,
    output result_t                        res_data
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int USED_W = $clog2(RES_DEPTH + 1);
    localparam int SH_W   = $clog2(MAX_WINDOW_LOG2 + FRAC_BITS + 1);

    back_state_t state_reg;
    back_state_t state_next;
    logic [CH_W-1:0]   idx_reg;
    logic [CH_W-1:0]   idx_next;
    logic [USED_W-1:0] used_reg;
    logic [USED_W-1:0] used_next;
    logic              issue;
    logic              idx_last;

    // Stage 1: entry read from the bank.
    logic              s1_valid_reg;
    acc_entry_t        s1_entry_reg;
    logic [CH_W-1:0]   s1_idx_reg;
    logic              s1_last_reg;

    // Stage 2: products.
    logic                         s2_valid_reg;
    logic signed [PSUM_BITS-1:0]  prod_sum_reg;
    logic signed [PSMP_BITS-1:0]  prod_max_reg;
    logic signed [PSMP_BITS-1:0]  prod_min_reg;
    logic [CH_W-1:0]              s2_idx_reg;
    logic                         s2_last_reg;

    logic signed [PSUM_BITS-1:0]  prod_sum_c;
    logic signed [PSMP_BITS-1:0]  prod_max_c;
    logic signed [PSMP_BITS-1:0]  prod_min_c;
    logic [SH_W-1:0]              sh_avg;
    logic signed [OUT_BITS-1:0]   hi_mv;
    logic signed [OUT_BITS-1:0]   lo_mv;

    assign idx_last = idx_reg == CH_W'(NUM_CHANNELS - 1);

    // Drain sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (bank_busy) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN:
            begin
                if (issue && idx_last) begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // A channel is issued only when the result queue has room reserved for it.
    always_comb
    begin
        issue      = (state_reg == BK_DRAIN) && (used_reg < USED_W'(RES_DEPTH));
        drain_done = issue && idx_last;
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (state_reg == BK_IDLE) begin
            idx_next = '0;
        end
        else if (issue) begin
            idx_next = idx_reg + CH_W'(1);
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (issue && !pop_fire) begin
            used_next = used_reg + USED_W'(1);
        end
        else if (!issue && pop_fire) begin
            used_next = used_reg - USED_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= BK_IDLE;
            idx_reg      <= '0;
            used_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            used_reg     <= used_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign rd_idx = idx_reg;

    assign prod_sum_c = $signed({1'b0, s1_entry_reg.sum}) * scale;
    assign prod_max_c = $signed({1'b0, s1_entry_reg.maxv}) * scale;
    assign prod_min_c = $signed({1'b0, s1_entry_reg.minv}) * scale;

    always_ff @(posedge clk)
    begin
        s1_entry_reg <= rd_data;
        s1_idx_reg   <= idx_reg;
        s1_last_reg  <= idx_last;
        prod_sum_reg <= prod_sum_c;
        prod_max_reg <= prod_max_c;
        prod_min_reg <= prod_min_c;
        s2_idx_reg   <= s1_idx_reg;
        s2_last_reg  <= s1_last_reg;
    end

    // Arithmetic right shift of a signed product is the floor division.
    assign sh_avg = SH_W'(win_eff) + SH_W'(FRAC_BITS);
    assign hi_mv  = sat_out(PSUM_BITS'(prod_max_reg) >>> FRAC_BITS);
    assign lo_mv  = sat_out(PSUM_BITS'(prod_min_reg) >>> FRAC_BITS);

    always_comb
    begin
        res_valid            = s2_valid_reg;
        res_data.out_channel = CHAN_BITS'(s2_idx_reg);
        res_data.avg_mv      = sat_out(prod_sum_reg >>> sh_avg);
        res_data.max_mv      = scale[SCALE_BITS-1] ? lo_mv : hi_mv;
        res_data.min_mv      = scale[SCALE_BITS-1] ? hi_mv : lo_mv;
        res_data.last        = s2_last_reg;
    end

endmodule

@@ rtl/mwmma_rfifo.sv @@
// Result queue between the scaling pipeline and the output port.
// Small register FIFO; the back end never writes it when full. Depends on mwmma_pkg.
module mwmma_rfifo
    import mwmma_pkg::*;
#(
    parameter int DEPTH = RES_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wr_data,
    input  logic    rd,
    output result_t rd_data,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (!wr && rd) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign empty   = count_reg == '0;

endmodule

@@ rtl/multichannel_window_min_max_avg_core.sv @@
// Top level of the windowed min/max/mean core: configuration registers and wiring.
// Instantiates mwmma_front, mwmma_bank, mwmma_back and mwmma_rfifo; uses mwmma_pkg.
//
// Usage. Samples enter through a queue-style port: a transaction completes on a
// rising edge with push high and full low, carrying the scan position (channel)
// and a raw 12-bit sample. Every sample is accumulated in the cycle it is
// accepted, so the input takes one sample per cycle while full is low. The
// transaction on the last channel that completes 2^window_log2 scans closes the
// window: its statistics are copied to a snapshot bank and the accumulators
// start over at once. The snapshot is drained one channel per cycle, while the
// result queue has room, through a three-stage scaling pipeline (bank read,
// multiply by the Q8.8 gain, floor shift and saturation) into a four-entry
// result queue; results leave it one per cycle while pop is held. Results are
// taken with pop while empty is low. If the receiver stalls, the result queue
// fills and the drain pauses; full rises only when the snapshot bank still
// holds an undrained window and the scan in progress is the one that would
// close the next window. Configuration writes (index 0: window_log2, index 1:
// scale_mv_q8) are always ready; the user is to make them only while the block
// is idle; the block does not enforce this. Reset clears the accumulators, the
// scan count and the result queue and restores the default configuration.
module multichannel_window_min_max_avg_core
    import mwmma_pkg::*;
#(
    parameter int NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int MAX_WINDOW_LOG2 = MAX_WINDOW_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        push,
    output logic                        full,
    input  logic [CHAN_BITS-1:0]        channel,
    input  logic [SAMPLE_BITS-1:0]      sample,

    output logic                        empty,
    input  logic                        pop,
    output logic [CHAN_BITS-1:0]        out_channel,
    output logic signed [OUT_BITS-1:0]  avg_mv,
    output logic signed [OUT_BITS-1:0]  max_mv,
    output logic signed [OUT_BITS-1:0]  min_mv,
    output logic                        last,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [SCALE_BITS-1:0]       cfg_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers.
    logic [WIN_CFG_BITS-1:0]        window_log2_reg;
    logic [WIN_CFG_BITS-1:0]        window_log2_next;
    logic signed [SCALE_BITS-1:0]   scale_reg;
    logic signed [SCALE_BITS-1:0]   scale_next;
    logic [WIN_BITS-1:0]            win_eff;

    logic                           accept;
    logic                           pop_fire;
    logic                           close;
    logic                           bank_busy;
    logic                           drain_done;
    logic [CH_W-1:0]                rd_idx;
    acc_entry_t                     rd_data;
    acc_entry_t [NUM_CHANNELS-1:0]  snap_data;
    logic                           res_valid;
    result_t                        res_data;
    result_t                        head;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        window_log2_next = window_log2_reg;
        scale_next       = scale_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW_LOG2: window_log2_next = cfg_data[WIN_CFG_BITS-1:0];
                CFG_SCALE_MV_Q8: scale_next       = $signed(cfg_data);
                default:         window_log2_next = window_log2_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            window_log2_reg <= WINDOW_RESET;
            scale_reg       <= SCALE_RESET;
        end
        else begin
            window_log2_reg <= window_log2_next;
            scale_reg       <= scale_next;
        end
    end

    // Out-of-range windows are pulled into the supported range.
    assign win_eff = clamp_window(window_log2_reg, MAX_WINDOW_LOG2);

    assign accept   = push && !full;
    assign pop_fire = pop && !empty;

    mwmma_front #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .channel   (channel),
        .sample    (sample),
        .win_eff   (win_eff),
        .bank_busy (bank_busy),
        .full      (full),
        .close     (close),
        .snap_data (snap_data)
    );

    mwmma_bank #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (close),
        .load_data  (snap_data),
        .rd_idx     (rd_idx),
        .drain_done (drain_done),
        .busy       (bank_busy),
        .rd_data    (rd_data)
    );

    mwmma_back #(
        .NUM_CHANNELS    (NUM_CHANNELS),
        .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .bank_busy  (bank_busy),
        .rd_data    (rd_data),
        .rd_idx     (rd_idx),
        .drain_done (drain_done),
        .win_eff    (win_eff),
        .scale      (scale_reg),
        .pop_fire   (pop_fire),
        .res_valid  (res_valid),
        .res_data   (res_data)
    );

    mwmma_rfifo #(
        .DEPTH (RES_DEPTH)
    ) u_rfifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res_data),
        .rd      (pop_fire),
        .rd_data (head),
        .empty   (empty)
    );

    assign out_channel = head.out_channel;
    assign avg_mv      = head.avg_mv;
    assign max_mv      = head.max_mv;
    assign min_mv      = head.min_mv;
    assign last        = head.last;

endmodule

@@ rtl/mwmma_checker.sv @@
// Port-level checker for the windowed min/max/mean core, bound to the top level.
// Watches only the top-level ports; depends on mwmma_pkg.
module mwmma_checker
    import mwmma_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       empty,
    input logic                       pop,
    input logic [CHAN_BITS-1:0]       out_channel,
    input logic signed [OUT_BITS-1:0] avg_mv,
    input logic                       last
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty during reset");

    // The last flag marks exactly the final channel of a window.
    a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last == (int'(out_channel) == NUM_CHANNELS - 1)))
        else $error("last flag does not match the final channel");

    // Within a window, results come out in channel order.
    a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) ##1 !empty
        |-> out_channel == $past(out_channel) + CHAN_BITS'(1))
        else $error("results out of channel order");

    // A waiting result stays put until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_channel) && $stable(avg_mv)))
        else $error("waiting result changed before it was taken");

endmodule

bind multichannel_window_min_max_avg_core mwmma_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_mwmma_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .out_channel (out_channel),
    .avg_mv      (avg_mv),
    .last        (last)
);

@@ verif/tb_multichannel_window_min_max_avg_core.sv @@
// Self-checking testbench for multichannel_window_min_max_avg_core.
// Drives sample transactions, predicts every window result in place and checks
// each popped result field by field. Depends on mwmma_pkg and the core RTL only.
module tb_multichannel_window_min_max_avg_core
    import mwmma_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = NUM_CHANNELS_DEF;
    localparam int LAST_CHANNEL  = CHANNELS - 1;
    localparam int IDLE_PCT      = 37;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int DIRECTED_ROWS = 22;

    // Full-scale samples on one channel on top of its scans; enough to push
    // the channel average past the output range under the extreme gains.
    localparam int FLOOD_SAMPLES = 20;

    // Bounds of the signed millivolt outputs.
    localparam longint MV_HI = (longint'(1) <<< (OUT_BITS - 1)) - 1;
    localparam longint MV_LO = -MV_HI - 1;

    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       push      = 1'b0;
    logic                       full;
    logic [CHAN_BITS-1:0]       channel   = '0;
    logic [SAMPLE_BITS-1:0]     sample    = '0;
    logic                       empty;
    logic                       pop       = 1'b0;
    logic [CHAN_BITS-1:0]       out_channel;
    logic signed [OUT_BITS-1:0] avg_mv;
    logic signed [OUT_BITS-1:0] max_mv;
    logic signed [OUT_BITS-1:0] min_mv;
    logic                       last;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [SCALE_BITS-1:0]      cfg_data  = '0;

    multichannel_window_min_max_avg_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .channel     (channel),
        .sample      (sample),
        .empty       (empty),
        .pop         (pop),
        .out_channel (out_channel),
        .avg_mv      (avg_mv),
        .max_mv      (max_mv),
        .min_mv      (min_mv),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // 8 ns clock period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Window predictor. It mirrors the accumulators of the core: a running
    // sum, maximum and minimum per channel and a count of completed scans.
    // Every accepted sample transaction is applied here; when a window
    // closes, the sixteen scaled results are appended to window_results,
    // which the result checker consumes in order.
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0]        sum_acc [CHANNELS];
    logic [SAMPLE_BITS-1:0]     max_acc [CHANNELS];
    logic [SAMPLE_BITS-1:0]     min_acc [CHANNELS];
    int unsigned                scans_done;
    int unsigned                windows_closed;
    logic [WIN_CFG_BITS-1:0]    window_cfg = WINDOW_RESET;
    logic signed [SCALE_BITS-1:0] gain_cfg = SCALE_RESET;
    result_t                    window_results [$];

    int unsigned                mismatch_count = 0;
    int unsigned                cycle_count = 0;
    bit                         no_idle = 1'b0;
    logic [CHAN_BITS-1:0]       scan_cursor = '0;
    result_t                    head_result;

    // Empty accumulators: a channel that sees no sample reports a maximum of
    // zero and a minimum of full scale.
    function automatic void clear_window();
        int i;
        for (i = 0; i < CHANNELS; i++)
        begin
            sum_acc[i] = '0;
            max_acc[i] = '0;
            min_acc[i] = '1;
        end
        scans_done = 0;
    endfunction

    // The programmed window is clamped to the range the core supports.
    function automatic int unsigned span_log2();
        int unsigned w;
        w = window_cfg;
        if (w < MIN_WINDOW)
        begin
            w = MIN_WINDOW;
        end
        if (w > MAX_WINDOW_DEF)
        begin
            w = MAX_WINDOW_DEF;
        end
        return w;
    endfunction

    // Multiply by the signed Q8.8 gain, divide by 2^shift rounding toward
    // minus infinity, then clip to the signed output range.
    function automatic logic signed [OUT_BITS-1:0] to_millivolts(
        input longint unsigned count,
        input int unsigned     shift
    );
        longint prod;
        longint q;
        prod = longint'(count) * longint'(gain_cfg);
        q = prod >>> shift;
        if (q > MV_HI)
        begin
            q = MV_HI;
        end
        else if (q < MV_LO)
        begin
            q = MV_LO;
        end
        return q[OUT_BITS-1:0];
    endfunction

    function automatic void accumulate_sample(
        input logic [CHAN_BITS-1:0]   ch,
        input logic [SAMPLE_BITS-1:0] s
    );
        int unsigned total;
        int unsigned w;
        int          i;
        result_t     r;
        logic signed [OUT_BITS-1:0] hi;
        logic signed [OUT_BITS-1:0] lo;

        // The sum saturates rather than wrapping.
        total = sum_acc[ch] + s;
        if (total > {SUM_BITS{1'b1}})
        begin
            total = {SUM_BITS{1'b1}};
        end
        sum_acc[ch] = total[SUM_BITS-1:0];
        if (s > max_acc[ch])
        begin
            max_acc[ch] = s;
        end
        if (s < min_acc[ch])
        begin
            min_acc[ch] = s;
        end

        // Only the last channel completes a scan. A window that was shrunk
        // after it started closes at the first scan that reaches the size.
        if (ch != LAST_CHANNEL)
        begin
            return;
        end
        scans_done++;
        w = span_log2();
        if (scans_done < (32'd1 << w))
        begin
            return;
        end

        for (i = 0; i < CHANNELS; i++)
        begin
            hi = to_millivolts(max_acc[i], FRAC_BITS);
            lo = to_millivolts(min_acc[i], FRAC_BITS);
            r.out_channel = CHAN_BITS'(i);
            r.avg_mv      = to_millivolts(sum_acc[i], w + FRAC_BITS);
            // A negative gain turns the largest count into the lowest voltage.
            r.max_mv      = (gain_cfg < 0) ? lo : hi;
            r.min_mv      = (gain_cfg < 0) ? hi : lo;
            r.last        = (i == LAST_CHANNEL);
            window_results.push_back(r);
        end
        clear_window();
        windows_closed++;
    endfunction

    // ------------------------------------------------------------------
    // Sample side. The transaction values are set with nonblocking
    // assignments at a rising edge and held until an edge sees push high
    // and full low. The predictor is updated at that edge.
    // ------------------------------------------------------------------
    task automatic push_sample(
        input logic [CHAN_BITS-1:0]   ch,
        input logic [SAMPLE_BITS-1:0] s
    );
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        channel <= ch;
        sample  <= s;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        accumulate_sample(ch, s);
    endtask

    // Half the samples follow an orderly scan; the rest land on a random
    // channel with a strong lean toward the last one so windows close often
    // and the other channels see uneven sample counts. Samples favor the
    // two ends of the converter range.
    task automatic random_item();
        logic [CHAN_BITS-1:0]   ch;
        logic [SAMPLE_BITS-1:0] s;
        if ($urandom_range(1) == 0)
        begin
            ch = scan_cursor;
            scan_cursor = scan_cursor + 1'b1;
        end
        else if ($urandom_range(3) != 0)
        begin
            ch = CHAN_BITS'(LAST_CHANNEL);
        end
        else
        begin
            ch = CHAN_BITS'($urandom_range(LAST_CHANNEL));
        end
        case ($urandom_range(7))
            0:       s = '0;
            1:       s = '1;
            default: s = SAMPLE_BITS'($urandom_range((1 << SAMPLE_BITS) - 1));
        endcase
        push_sample(ch, s);
    endtask

    task automatic run_windows(input int unsigned count);
        int unsigned target;
        target = windows_closed + count;
        while (windows_closed < target)
        begin
            random_item();
        end
    endtask

    // Stop sending, wait until every predicted result has been popped, then
    // let the pipeline run on idle so that no work is left in flight.
    task automatic settle();
        push <= 1'b0;
        while (window_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write on the configuration channel; the predictor picks up the
    // new value at the handshake edge.
    task automatic cfg_write(
        input logic [CFG_IDX_BITS-1:0] idx,
        input logic [SCALE_BITS-1:0]   data
    );
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW_LOG2)
        begin
            window_cfg = data[WIN_CFG_BITS-1:0];
        end
        else if (idx == CFG_SCALE_MV_Q8)
        begin
            gain_cfg = data;
        end
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Result side. Outputs are sampled at the rising edge, before the core
    // updates them, and a transaction is one with pop high and empty low.
    // Each one is matched against the oldest predicted result.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (window_results.size() == 0)
            begin
                $display("%0t: result for channel %0d with none expected", $time, out_channel);
                mismatch_count++;
            end
            else
            begin
                head_result = window_results.pop_front();
                if (out_channel !== head_result.out_channel)
                begin
                    $display("%0t: out_channel expected %0d got %0d",
                             $time, head_result.out_channel, out_channel);
                    mismatch_count++;
                end
                if (avg_mv !== head_result.avg_mv)
                begin
                    $display("%0t: channel %0d avg_mv expected %0d got %0d",
                             $time, head_result.out_channel, head_result.avg_mv, avg_mv);
                    mismatch_count++;
                end
                if (max_mv !== head_result.max_mv)
                begin
                    $display("%0t: channel %0d max_mv expected %0d got %0d",
                             $time, head_result.out_channel, head_result.max_mv, max_mv);
                    mismatch_count++;
                end
                if (min_mv !== head_result.min_mv)
                begin
                    $display("%0t: channel %0d min_mv expected %0d got %0d",
                             $time, head_result.out_channel, head_result.min_mv, min_mv);
                    mismatch_count++;
                end
                if (last !== head_result.last)
                begin
                    $display("%0t: channel %0d last expected %0d got %0d",
                             $time, head_result.out_channel, head_result.last, last);
                    mismatch_count++;
                end
            end
        end
        pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("multichannel_window_min_max_avg_core verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows. They run with a unity gain (256 in Q8.8), so counts
    // read straight through as millivolts, and with window_log2 written as
    // zero, which the core must raise to the minimum of 16 scans. Channel 0
    // sees both ends of the sample range, channels 4 to 13 see nothing and
    // must report the empty-window values, and the closing sample on the
    // last channel is the only zero there, so the typed minimum proves it
    // was accumulated before the results were formed.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [CHAN_BITS-1:0]       ch;
        logic [SAMPLE_BITS-1:0]     smp;
        logic                       typed;
        logic signed [OUT_BITS-1:0] avg;
        logic signed [OUT_BITS-1:0] hi;
        logic signed [OUT_BITS-1:0] lo;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{4'd0,  12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd0,  12'd0,    1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd1,  12'd2048, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd2,  12'hAAA,  1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd3,  12'h555,  1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd14, 12'd1,    1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        '{4'd15, 12'd4095, 1'b0, 20'sd0, 20'sd0, 20'sd0},
        // Closes the window: 15 * 4095 / 16 floors to 3839.
        '{4'd15, 12'd0,    1'b1, 20'sd3839, 20'sd4095, 20'sd0}
    };

    // Gain settings for the general random windows: a zero gain on a 32-scan
    // window and the smallest negative gain. The two extreme gains are run
    // by the flood windows further down.
    typedef struct packed {
        logic [WIN_CFG_BITS-1:0] win;
        logic [SCALE_BITS-1:0]   gain;
    } setting_t;

    setting_t random_settings [2] = '{
        '{4'd5, 16'h0000},
        '{4'd4, 16'hFFFF}
    };

    initial
    begin
        int          k;
        int unsigned queued;

        clear_window();
        windows_closed = 0;

        // Reset is held low from time zero and released at a rising edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_write(CFG_WINDOW_LOG2, 16'd0);
        cfg_write(CFG_SCALE_MV_Q8, 16'd256);
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            queued = window_results.size();
            push_sample(directed_rows[k].ch, directed_rows[k].smp);
            // A typed row fixes the result of its own channel, which is the
            // last one of the window that it closes.
            if (directed_rows[k].typed && (window_results.size() > queued))
            begin
                window_results[window_results.size() - 1].avg_mv = directed_rows[k].avg;
                window_results[window_results.size() - 1].max_mv = directed_rows[k].hi;
                window_results[window_results.size() - 1].min_mv = directed_rows[k].lo;
            end
        end
        settle();

        // General random windows under a spread of gains.
        for (k = 0; k < 2; k++)
        begin
            cfg_write(CFG_WINDOW_LOG2, SCALE_BITS'(random_settings[k].win));
            cfg_write(CFG_SCALE_MV_Q8, random_settings[k].gain);
            run_windows(1);
            settle();
        end

        // Shrink the window part way through: 20 scans into a 64-scan window
        // the size drops to 16, so the next completed scan must close it.
        cfg_write(CFG_WINDOW_LOG2, 16'd6);
        cfg_write(CFG_SCALE_MV_Q8, SCALE_BITS'($urandom));
        while (scans_done < 20)
        begin
            random_item();
        end
        settle();
        cfg_write(CFG_WINDOW_LOG2, 16'd4);
        run_windows(1);
        settle();

        // Largest register value, clamped to 4096 scans, so no window closes
        // here and these samples carry over into the next window. From here
        // through the first flood window both sides run with random idle
        // insertion turned off.
        no_idle = 1'b1;
        cfg_write(CFG_WINDOW_LOG2, 16'd15);
        cfg_write(CFG_SCALE_MV_Q8, SCALE_RESET);
        repeat (20) push_sample(CHAN_BITS'($urandom_range(LAST_CHANNEL - 1)),
                                SAMPLE_BITS'($urandom));
        settle();

        // Flood one channel with full-scale samples inside a 16-scan window,
        // once with the largest positive gain and once with the most negative
        // one; its average clips at both output ends.
        cfg_write(CFG_WINDOW_LOG2, 16'd4);
        cfg_write(CFG_SCALE_MV_Q8, 16'h7FFF);
        repeat (FLOOD_SAMPLES) push_sample(4'd7, '1);
        run_windows(1);
        settle();
        no_idle = 1'b0;
        cfg_write(CFG_SCALE_MV_Q8, 16'h8000);
        repeat (FLOOD_SAMPLES) push_sample(4'd9, '1);
        run_windows(1);
        settle();

        if (mismatch_count == 0)
        begin
            $display("multichannel_window_min_max_avg_core verification clean");
        end
        else
        begin
            $display("multichannel_window_min_max_avg_core verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mwmma_pkg.sv
rtl/mwmma_front.sv
rtl/mwmma_bank.sv
rtl/mwmma_back.sv
rtl/mwmma_rfifo.sv
rtl/multichannel_window_min_max_avg_core.sv
rtl/mwmma_checker.sv
verif/tb_multichannel_window_min_max_avg_core.sv
